// File: rtl/lzotd_pkg.sv
// Package for the LZO1X token decoder: parse phases, result codes and the
// result record. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzotd_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int SUM_BITS    = LENGTH_BITS + 1;

	// Result kinds.
	localparam logic [1:0] KIND_LIT   = 2'd0;
	localparam logic [1:0] KIND_MATCH = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERR   = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_LIT_RUN = 2'd1;
	localparam logic [1:0] ERR_LEN_OVF = 2'd2;
	localparam logic [1:0] ERR_BAD_END = 2'd3;

	localparam logic [7:0]  FIRST_BIAS   = 8'd17;
	localparam logic [15:0] M1_LONG_BASE = 16'h0801;
	localparam logic [15:0] M4_BASE      = 16'h4000;
	localparam logic [SUM_BITS-1:0] LIT_RUN_LIMIT = SUM_BITS'(16389);
	localparam logic [9:0] EXT_ZERO  = 10'd255;
	localparam logic [9:0] EXT_LIT   = 10'd15;
	localparam logic [9:0] EXT_M3    = 10'd31;
	localparam logic [9:0] EXT_M4    = 10'd7;

	typedef enum logic [12:0] {
		PH_FIRST    = 13'h0001,
		PH_TOKEN    = 13'h0002,
		PH_LITEXT   = 13'h0004,
		PH_LIT      = 13'h0008,
		PH_AFTERRUN = 13'h0010,
		PH_M1L_OFF  = 13'h0020,
		PH_MTOKEN   = 13'h0040,
		PH_M1S_OFF  = 13'h0080,
		PH_M2_OFF   = 13'h0100,
		PH_LENEXT   = 13'h0200,
		PH_OFFLO    = 13'h0400,
		PH_OFFHI    = 13'h0800,
		PH_TRAIL    = 13'h1000
	} phase_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [7:0]             literal_value;
		logic [15:0]            match_distance;
		logic [LENGTH_BITS-1:0] match_length;
		logic [1:0]             error_code;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/lzo1x_token_decoder_top.sv
// LZO1X token decoder top level: parses the compressed byte stream into
// literals, match commands, an end marker and errors. Depends on lzotd_pkg.
//
// Usage: compressed bytes enter on the data channel (data_valid, data_stall,
// data_byte, last_byte), one per transaction; last_byte marks the final byte
// of a stream. Results leave on the result channel (result_valid,
// result_stall and the five result fields), zero or one per input byte.
// A byte's result is registered in the result register, or in the skid
// register while a result waits; a new byte can be taken in every cycle unless
// data_stall is high. Parse state and result come from one short logic pass.
// A two-entry output buffer (result register plus skid register) lets the
// block take a byte while a result waits; data_stall rises only when both
// entries are full, and falls once the receiver takes a result.
// After an end marker or an error, bytes are swallowed without results up to
// and including the next byte marked last; any last byte returns the parser
// to its start-of-stream state. Reset clears the parser and empties the
// output buffer; history copying is done downstream.
`timescale 1ns / 1ps
`default_nettype none

module lzo1x_token_decoder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic data_valid,
	output logic      data_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic last_byte,
	output logic      result_valid,
	input  wire logic result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  literal_value,
	output logic [15:0] match_distance,
	output logic [lzotd_pkg::LENGTH_BITS-1:0] match_length,
	output logic [1:0]  error_code
);

	localparam int LB = lzotd_pkg::LENGTH_BITS;
	localparam int SB = lzotd_pkg::SUM_BITS;

	lzotd_pkg::phase_t phase_q, phase_d;
	logic [LB-1:0] run_q, run_d;
	logic [7:0]    hold_q, hold_d;
	logic [7:0]    offl_q, offl_d;
	logic [1:0]    trail_q, trail_d;
	logic          done_q, done_d;

	lzotd_pkg::res_t out_q, skid_q, res_c;
	logic out_valid_q, skid_valid_q;
	logic res_fire;
	logic accept, take;

	// Shared helpers.
	logic [4:0]    mt_len;
	lzotd_pkg::phase_t mt_phase;
	logic [9:0]    ext_add;
	logic [SB-1:0] ext_sum;
	logic [LB-1:0] ext_sat;
	logic [SB-1:0] len_full;
	logic [15:0]   w_off;
	logic [15:0]   m4_base;
	logic [7:0]    first_t;

	assign accept     = data_valid && !data_stall;
	assign take       = out_valid_q && !result_stall;
	assign data_stall = skid_valid_q;

	always_comb begin
		mt_len = (data_byte >= 8'd32) ? data_byte[4:0] : {2'b00, data_byte[2:0]};
		if (data_byte >= 8'd64) begin
			mt_phase = lzotd_pkg::PH_M2_OFF;
		end else if (mt_len != 5'd0) begin
			mt_phase = lzotd_pkg::PH_OFFLO;
		end else begin
			mt_phase = lzotd_pkg::PH_LENEXT;
		end

		if (data_byte == 8'd0) begin
			ext_add = lzotd_pkg::EXT_ZERO;
		end else if (phase_q == lzotd_pkg::PH_LITEXT) begin
			ext_add = lzotd_pkg::EXT_LIT + {2'b00, data_byte};
		end else if (hold_q >= 8'd32) begin
			ext_add = lzotd_pkg::EXT_M3 + {2'b00, data_byte};
		end else begin
			ext_add = lzotd_pkg::EXT_M4 + {2'b00, data_byte};
		end
		ext_sum = {1'b0, run_q} + SB'(ext_add);
		// The extension sum saturates at the largest representable length.
		ext_sat = ext_sum[LB] ? {LB{1'b1}} : ext_sum[LB-1:0];

		len_full = {1'b0, run_q} + SB'(2);
		w_off    = {data_byte, offl_q};
		m4_base  = {1'b0, hold_q[3], w_off[15:2]};
		first_t  = data_byte - lzotd_pkg::FIRST_BIAS;
	end

	always_comb begin
		phase_d  = phase_q;
		run_d    = run_q;
		hold_d   = hold_q;
		offl_d   = offl_q;
		trail_d  = trail_q;
		done_d   = done_q;
		res_fire = 1'b0;
		res_c    = '0;

		if (done_q) begin
			if (last_byte) begin
				phase_d = lzotd_pkg::PH_FIRST;
				run_d   = '0;
				hold_d  = '0;
				offl_d  = '0;
				trail_d = '0;
				done_d  = 1'b0;
			end
		end else begin
			unique case (phase_q)
				lzotd_pkg::PH_FIRST, lzotd_pkg::PH_TOKEN: begin
					if (phase_q == lzotd_pkg::PH_FIRST && data_byte > lzotd_pkg::FIRST_BIAS) begin
						if (first_t < 8'd4) begin
							trail_d = first_t[1:0];
							phase_d = lzotd_pkg::PH_TRAIL;
						end else begin
							run_d   = LB'(first_t);
							phase_d = lzotd_pkg::PH_LIT;
						end
					end else if (data_byte >= 8'd16) begin
						hold_d  = data_byte;
						run_d   = LB'(mt_len);
						phase_d = mt_phase;
					end else if (data_byte == 8'd0) begin
						run_d   = '0;
						phase_d = lzotd_pkg::PH_LITEXT;
					end else begin
						run_d   = LB'(data_byte) + LB'(3);
						phase_d = lzotd_pkg::PH_LIT;
					end
				end
				lzotd_pkg::PH_LITEXT: begin
					if (data_byte == 8'd0) begin
						run_d = ext_sat;
					end else if ({1'b0, ext_sat} >= lzotd_pkg::LIT_RUN_LIMIT) begin
						res_fire         = 1'b1;
						res_c.kind       = lzotd_pkg::KIND_ERR;
						res_c.error_code = lzotd_pkg::ERR_LIT_RUN;
						done_d           = 1'b1;
					end else begin
						run_d   = ext_sat + LB'(3);
						phase_d = lzotd_pkg::PH_LIT;
					end
				end
				lzotd_pkg::PH_LIT: begin
					res_fire            = 1'b1;
					res_c.kind          = lzotd_pkg::KIND_LIT;
					res_c.literal_value = data_byte;
					if (run_q != '0) begin
						run_d = run_q - LB'(1);
					end
					if (run_q <= LB'(1)) begin
						phase_d = lzotd_pkg::PH_AFTERRUN;
					end
				end
				lzotd_pkg::PH_TRAIL: begin
					res_fire            = 1'b1;
					res_c.kind          = lzotd_pkg::KIND_LIT;
					res_c.literal_value = data_byte;
					if (trail_q != 2'd0) begin
						trail_d = trail_q - 2'd1;
					end
					if (trail_q <= 2'd1) begin
						phase_d = lzotd_pkg::PH_MTOKEN;
					end
				end
				lzotd_pkg::PH_AFTERRUN, lzotd_pkg::PH_MTOKEN: begin
					hold_d = data_byte;
					if (data_byte >= 8'd16) begin
						run_d   = LB'(mt_len);
						phase_d = mt_phase;
					end else if (phase_q == lzotd_pkg::PH_AFTERRUN) begin
						phase_d = lzotd_pkg::PH_M1L_OFF;
					end else begin
						phase_d = lzotd_pkg::PH_M1S_OFF;
					end
				end
				lzotd_pkg::PH_M1L_OFF: begin
					res_fire             = 1'b1;
					res_c.kind           = lzotd_pkg::KIND_MATCH;
					res_c.match_distance = lzotd_pkg::M1_LONG_BASE + {10'd0, hold_q[7:2]}
						+ {6'd0, data_byte, 2'b00};
					res_c.match_length   = LB'(3);
					trail_d = hold_q[1:0];
					phase_d = (hold_q[1:0] != 2'd0) ? lzotd_pkg::PH_TRAIL : lzotd_pkg::PH_TOKEN;
				end
				lzotd_pkg::PH_M1S_OFF: begin
					res_fire             = 1'b1;
					res_c.kind           = lzotd_pkg::KIND_MATCH;
					res_c.match_distance = 16'd1 + {10'd0, hold_q[7:2]}
						+ {6'd0, data_byte, 2'b00};
					res_c.match_length   = LB'(2);
					trail_d = hold_q[1:0];
					phase_d = (hold_q[1:0] != 2'd0) ? lzotd_pkg::PH_TRAIL : lzotd_pkg::PH_TOKEN;
				end
				lzotd_pkg::PH_M2_OFF: begin
					res_fire             = 1'b1;
					res_c.kind           = lzotd_pkg::KIND_MATCH;
					res_c.match_distance = 16'd1 + {13'd0, hold_q[4:2]}
						+ {5'd0, data_byte, 3'b000};
					res_c.match_length   = LB'(hold_q[7:5]) + LB'(1);
					trail_d = hold_q[1:0];
					phase_d = (hold_q[1:0] != 2'd0) ? lzotd_pkg::PH_TRAIL : lzotd_pkg::PH_TOKEN;
				end
				lzotd_pkg::PH_LENEXT: begin
					run_d = ext_sat;
					if (data_byte != 8'd0) begin
						phase_d = lzotd_pkg::PH_OFFLO;
					end
				end
				lzotd_pkg::PH_OFFLO: begin
					offl_d  = data_byte;
					phase_d = lzotd_pkg::PH_OFFHI;
				end
				lzotd_pkg::PH_OFFHI: begin
					res_fire = 1'b1;
					if (hold_q < 8'd32 && m4_base == 16'd0) begin
						// End-of-stream marker; its length is ignored.
						res_c.kind       = last_byte ? lzotd_pkg::KIND_END : lzotd_pkg::KIND_ERR;
						res_c.error_code = last_byte ? lzotd_pkg::ERR_NONE : lzotd_pkg::ERR_BAD_END;
						done_d           = 1'b1;
					end else if (len_full[LB]) begin
						res_c.kind       = lzotd_pkg::KIND_ERR;
						res_c.error_code = lzotd_pkg::ERR_LEN_OVF;
						done_d           = 1'b1;
					end else begin
						res_c.kind           = lzotd_pkg::KIND_MATCH;
						res_c.match_distance = (hold_q >= 8'd32) ? 16'd1 + {2'b00, w_off[15:2]}
							: m4_base + lzotd_pkg::M4_BASE;
						res_c.match_length   = len_full[LB-1:0];
						trail_d = offl_q[1:0];
						phase_d = (offl_q[1:0] != 2'd0) ? lzotd_pkg::PH_TRAIL
							: lzotd_pkg::PH_TOKEN;
					end
				end
				default: begin
					phase_d = lzotd_pkg::PH_TOKEN;
				end
			endcase

			if (last_byte) begin
				// A last byte must close the stream; anything else is a bad end.
				if (!(res_fire && (res_c.kind == lzotd_pkg::KIND_END
						|| res_c.kind == lzotd_pkg::KIND_ERR))) begin
					res_fire         = 1'b1;
					res_c            = '0;
					res_c.kind       = lzotd_pkg::KIND_ERR;
					res_c.error_code = lzotd_pkg::ERR_BAD_END;
				end
				phase_d = lzotd_pkg::PH_FIRST;
				run_d   = '0;
				hold_d  = '0;
				offl_d  = '0;
				trail_d = '0;
				done_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzotd_pkg::PH_FIRST;
			run_q   <= '0;
			hold_q  <= '0;
			offl_q  <= '0;
			trail_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			hold_q  <= hold_d;
			offl_q  <= offl_d;
			trail_q <= trail_d;
			done_q  <= done_d;
		end
	end

	// Output buffer: the result register, backed by a skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept && res_fire;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= accept && res_fire;
			end else if (accept && res_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_q <= skid_q;
		end else if ((take || !out_valid_q) && accept && res_fire) begin
			out_q <= res_c;
		end
		if (!take && out_valid_q && accept && res_fire) begin
			skid_q <= res_c;
		end
	end

	assign result_valid   = out_valid_q;
	assign kind           = out_q.kind;
	assign literal_value  = out_q.literal_value;
	assign match_distance = out_q.match_distance;
	assign match_length   = out_q.match_length;
	assign error_code     = out_q.error_code;

endmodule

`default_nettype wire

// File: rtl/lzotd_checker.sv
// Port-level checker for the LZO1X token decoder, bound to the top level.
// Depends on lzotd_pkg and lzo1x_token_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module lzotd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic data_valid,
	input wire logic data_stall,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	input wire logic result_valid,
	input wire logic result_stall,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  literal_value,
	input wire logic [15:0] match_distance,
	input wire logic [lzotd_pkg::LENGTH_BITS-1:0] match_length,
	input wire logic [1:0]  error_code
);

	// A stalled result transaction stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(kind) && $stable(literal_value)
			&& $stable(match_distance) && $stable(match_length) && $stable(error_code))
		else $error("result payload changed while stalled");

	// An error code is reported exactly with the error kind.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((kind == lzotd_pkg::KIND_ERR) == (error_code != lzotd_pkg::ERR_NONE)))
		else $error("error_code does not agree with kind");

	// A match command always copies at least two bytes from a non-zero distance.
	a_match_sane: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == lzotd_pkg::KIND_MATCH
			|-> match_distance != 16'd0 && match_length >= lzotd_pkg::LENGTH_BITS'(2))
		else $error("match command with bad distance or length");

	// Non-literal results carry no literal byte.
	a_lit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != lzotd_pkg::KIND_LIT |-> literal_value == 8'd0)
		else $error("literal_value set on a non-literal result");

endmodule

bind lzo1x_token_decoder_top lzotd_checker u_lzotd_checker (.*);

`default_nettype wire

// File: tb/lzotd_token_check.sv
// Result check for the LZO1X token decoder: follows the parse of every
// accepted compressed byte, queues the result it should give and compares
// each delivered result field by field. Depends on lzotd_pkg.
`timescale 1ns / 1ps

module lzotd_token_check
	import lzotd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   data_valid,
	input  logic                   data_stall,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic [1:0]             kind,
	input  logic [7:0]             literal_value,
	input  logic [15:0]            match_distance,
	input  logic [LENGTH_BITS-1:0] match_length,
	input  logic [1:0]             error_code,
	output int                     fail_count = 0,
	output int                     outstanding = 0
);

	localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

	phase_t      phase = PH_FIRST;
	logic [63:0] run_cnt = '0;
	logic [7:0]  tok = '0;
	logic [7:0]  off_lo = '0;
	logic [1:0]  trail = '0;
	logic        swallowing = 1'b0;
	res_t        expected_q[$];
	res_t        want;
	int          mismatches = 0;

	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		return (a + b > LEN_MAX) ? LEN_MAX : a + b;
	endfunction

	task automatic clear_parser();
		phase = PH_FIRST;
		run_cnt = '0;
		tok = '0;
		off_lo = '0;
		trail = '0;
		swallowing = 1'b0;
	endtask

	// A token of 16 or more opens an M2, M3 or M4 match.
	task automatic open_match(input logic [7:0] b);
		logic [7:0] t;
		tok = b;
		if (b >= 8'd64) begin
			phase = PH_M2_OFF;
		end else begin
			t = (b >= 8'd32) ? (b & 8'd31) : (b & 8'd7);
			run_cnt = 64'(t);
			if (t != 8'd0) begin
				phase = PH_OFFLO;
			end else begin
				phase = PH_LENEXT;
			end
		end
	endtask

	task automatic close_match(input logic [1:0] t);
		trail = t;
		if (t != 2'd0) begin
			phase = PH_TRAIL;
		end else begin
			phase = PH_TOKEN;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		res_t        r;
		logic        emit;
		logic        as_token;
		logic [63:0] v;
		logic [63:0] d;
		logic [63:0] len;
		logic [15:0] w;
		r = '0;
		emit = 1'b0;
		as_token = 1'b0;
		d = '0;
		len = '0;
		// After an end marker or an error everything is dropped up to the last byte.
		if (swallowing) begin
			if (fin) clear_parser();
			return;
		end
		case (phase)
			PH_FIRST: begin
				if (b > FIRST_BIAS) begin
					v = 64'(b - FIRST_BIAS);
					if (v < 64'd4) begin
						trail = v[1:0];
						phase = PH_TRAIL;
					end else begin
						run_cnt = v;
						phase = PH_LIT;
					end
				end else begin
					as_token = 1'b1;
				end
			end
			PH_TOKEN: as_token = 1'b1;
			PH_LITEXT: begin
				if (b == 8'd0) begin
					run_cnt = sat_sum(run_cnt, 64'(EXT_ZERO));
				end else begin
					v = sat_sum(run_cnt, 64'(EXT_LIT) + 64'(b));
					if (v >= 64'(LIT_RUN_LIMIT)) begin
						emit = 1'b1;
						r.kind = KIND_ERR;
						r.error_code = ERR_LIT_RUN;
						swallowing = 1'b1;
					end else begin
						run_cnt = v + 64'd3;
						phase = PH_LIT;
					end
				end
			end
			PH_LIT: begin
				emit = 1'b1;
				r.kind = KIND_LIT;
				r.literal_value = b;
				if (run_cnt != 0) run_cnt--;
				if (run_cnt == 0) phase = PH_AFTERRUN;
			end
			PH_TRAIL: begin
				emit = 1'b1;
				r.kind = KIND_LIT;
				r.literal_value = b;
				if (trail != 0) trail--;
				if (trail == 0) phase = PH_MTOKEN;
			end
			PH_AFTERRUN, PH_MTOKEN: begin
				if (b >= 8'd16) begin
					open_match(b);
				end else begin
					tok = b;
					if (phase == PH_AFTERRUN) begin
						phase = PH_M1L_OFF;
					end else begin
						phase = PH_M1S_OFF;
					end
				end
			end
			PH_M1L_OFF: begin
				emit = 1'b1;
				r.kind = KIND_MATCH;
				d = 64'(M1_LONG_BASE) + 64'(tok >> 2) + (64'(b) << 2);
				len = 64'd3;
				close_match(tok[1:0]);
			end
			PH_M1S_OFF: begin
				emit = 1'b1;
				r.kind = KIND_MATCH;
				d = 64'd1 + 64'(tok >> 2) + (64'(b) << 2);
				len = 64'd2;
				close_match(tok[1:0]);
			end
			PH_M2_OFF: begin
				emit = 1'b1;
				r.kind = KIND_MATCH;
				d = 64'd1 + 64'((tok >> 2) & 8'd7) + (64'(b) << 3);
				len = 64'(tok >> 5) + 64'd1;
				close_match(tok[1:0]);
			end
			PH_LENEXT: begin
				if (b == 8'd0) begin
					run_cnt = sat_sum(run_cnt, 64'(EXT_ZERO));
				end else begin
					run_cnt = sat_sum(run_cnt,
						((tok >= 8'd32) ? 64'(EXT_M3) : 64'(EXT_M4)) + 64'(b));
					phase = PH_OFFLO;
				end
			end
			PH_OFFLO: begin
				off_lo = b;
				phase = PH_OFFHI;
			end
			PH_OFFHI: begin
				w = {b, off_lo};
				emit = 1'b1;
				if (tok >= 8'd32) begin
					d = 64'd1 + 64'(w >> 2);
				end else begin
					d = ((64'(tok) & 64'd8) << 11) + 64'(w >> 2);
				end
				if (tok < 8'd32 && d == 0) begin
					// End-of-stream marker: only valid on the final byte.
					r.kind = fin ? KIND_END : KIND_ERR;
					r.error_code = fin ? ERR_NONE : ERR_BAD_END;
					swallowing = 1'b1;
				end else begin
					if (tok < 8'd32) d = d + 64'(M4_BASE);
					len = run_cnt + 64'd2;
					if (len > LEN_MAX) begin
						r.kind = KIND_ERR;
						r.error_code = ERR_LEN_OVF;
						swallowing = 1'b1;
					end else begin
						r.kind = KIND_MATCH;
						close_match(off_lo[1:0]);
					end
				end
			end
			default: phase = PH_TOKEN;
		endcase
		if (as_token) begin
			if (b >= 8'd16) begin
				open_match(b);
			end else if (b == 8'd0) begin
				run_cnt = '0;
				phase = PH_LITEXT;
			end else begin
				run_cnt = 64'(b) + 64'd3;
				phase = PH_LIT;
			end
		end
		if (fin) begin
			if (!(emit && (r.kind == KIND_END || r.kind == KIND_ERR))) begin
				emit = 1'b1;
				r.kind = KIND_ERR;
				r.error_code = ERR_BAD_END;
			end
			clear_parser();
		end
		if (emit) begin
			if (r.kind != KIND_LIT) r.literal_value = '0;
			if (r.kind == KIND_MATCH) begin
				r.match_distance = d[15:0];
				r.match_length = len[LENGTH_BITS-1:0];
			end
			if (r.kind != KIND_ERR) r.error_code = ERR_NONE;
			expected_q.push_back(r);
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, what, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_q.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual kind %0d",
						$time, kind);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("kind", want.kind, kind);
					check_field("literal_value", want.literal_value, literal_value);
					check_field("match_distance", want.match_distance, match_distance);
					check_field("match_length", want.match_length, match_length);
					check_field("error_code", want.error_code, error_code);
				end
			end
			if (data_valid && !data_stall) parse_byte(data_byte, last_byte);
		end
		fail_count <= mismatches;
		outstanding <= expected_q.size();
	end

endmodule

// File: tb/tb_top.sv
// Top of the LZO1X token decoder testbench: clock, reset, compressed-stream
// stimulus and the verdict. Depends on lzotd_pkg, the decoder and lzotd_token_check.
`timescale 1ns / 1ps

module tb_top;
	import lzotd_pkg::*;

	typedef enum int {AT_TOKEN, AT_AFTER_RUN, AT_AFTER_TRAIL} spot_t;
	typedef enum int {MF_M1, MF_M2, MF_M3, MF_M4} match_form_t;

	localparam int WATCHDOG_LIMIT = 4000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   data_valid = 1'b0;
	logic                   data_stall;
	logic [7:0]             data_byte = '0;
	logic                   last_byte = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [1:0]             kind;
	logic [7:0]             literal_value;
	logic [15:0]            match_distance;
	logic [LENGTH_BITS-1:0] match_length;
	logic [1:0]             error_code;

	int         fail_count;
	int         outstanding;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         quiet_cycles = 0;
	int         sent_bytes = 0;
	logic [7:0] frame_q[$];

	lzo1x_token_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.literal_value(literal_value),
		.match_distance(match_distance),
		.match_length(match_length),
		.error_code(error_code)
	);

	lzotd_token_check u_token_check (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.literal_value(literal_value),
		.match_distance(match_distance),
		.match_length(match_length),
		.error_code(error_code),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Ends the run when neither channel completes a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (data_valid && !data_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_one(input logic [7:0] b, input logic fin);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			data_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (data_stall);
	endtask

	task automatic ship_frame();
		foreach (frame_q[i]) send_one(frame_q[i], i == frame_q.size() - 1);
		sent_bytes += frame_q.size();
		frame_q.delete();
	endtask

	// Holds the sender back until every queued result has been delivered.
	task automatic drain();
		data_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic add_random(input int n);
		repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_zeros(input int n);
		repeat (n) frame_q.push_back(8'h00);
	endtask

	task automatic add_literal_run();
		int z;
		int fin_b;
		if ($urandom_range(0, 3) != 0) begin
			fin_b = $urandom_range(1, 15);
			frame_q.push_back(8'(fin_b));
			add_random(fin_b + 3);
		end else begin
			z = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
			fin_b = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
			frame_q.push_back(8'h00);
			add_zeros(z);
			frame_q.push_back(8'(fin_b));
			add_random(255 * z + fin_b + 18);
		end
	endtask

	task automatic add_match(input bit allow_m1, output int trail);
		match_form_t form;
		logic [7:0]  t;
		logic [7:0]  lo;
		logic [7:0]  hi;
		form = match_form_t'($urandom_range(allow_m1 ? 0 : 1, 3));
		case (form)
			MF_M1, MF_M2: begin
				if (form == MF_M1) begin
					t = 8'($urandom_range(0, 15));
				end else begin
					t = 8'($urandom_range(64, 255));
				end
				frame_q.push_back(t);
				frame_q.push_back(8'($urandom_range(0, 255)));
				trail = t[1:0];
			end
			default: begin
				if (form == MF_M3) begin
					t = 8'($urandom_range(32, 63));
					if ($urandom_range(0, 2) == 0) t[4:0] = '0;
				end else begin
					t = 8'($urandom_range(16, 31));
					if ($urandom_range(0, 2) == 0) t[2:0] = '0;
				end
				frame_q.push_back(t);
				if ((form == MF_M3 && t[4:0] == 0) || (form == MF_M4 && t[2:0] == 0)) begin
					add_zeros(($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
					frame_q.push_back(8'($urandom_range(1, 255)));
				end
				lo = 8'($urandom_range(0, 255));
				hi = 8'($urandom_range(0, 255));
				// A zero M4 distance would be an end marker.
				if (form == MF_M4 && !t[3] && hi == 8'd0 && lo < 8'd4) lo[2] = 1'b1;
				frame_q.push_back(lo);
				frame_q.push_back(hi);
				trail = lo[1:0];
			end
		endcase
		add_random(trail);
	endtask

	task automatic add_end_marker();
		if ($urandom_range(0, 1) == 0) begin
			frame_q = {frame_q, 8'h11, 8'($urandom_range(0, 3)), 8'h00};
		end else begin
			frame_q = {frame_q, 8'h10, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 3)), 8'h00};
		end
	endtask

	task automatic build_stream(input int n_ops);
		spot_t spot;
		int    fb;
		int    trail;
		if ($urandom_range(0, 2) == 0) begin
			fb = ($urandom_range(0, 1) == 0) ? $urandom_range(18, 21) : $urandom_range(22, 60);
			frame_q.push_back(8'(fb));
			add_random(fb - 17);
			spot = (fb < 21) ? AT_AFTER_TRAIL : AT_AFTER_RUN;
		end else begin
			// A leading match token above 17 would be read as a literal count.
			add_literal_run();
			spot = AT_AFTER_RUN;
		end
		repeat (n_ops) begin
			if (spot == AT_TOKEN && $urandom_range(0, 2) == 0) begin
				add_literal_run();
				spot = AT_AFTER_RUN;
			end else begin
				add_match(spot != AT_TOKEN, trail);
				spot = (trail != 0) ? AT_AFTER_TRAIL : AT_TOKEN;
			end
		end
		add_end_marker();
	endtask

	task automatic random_traffic(input int n_bytes);
		int stop_at;
		int mix;
		int cut;
		stop_at = sent_bytes + n_bytes;
		while (sent_bytes < stop_at) begin
			mix = $urandom_range(0, 99);
			if (mix < 87) begin
				build_stream($urandom_range(1, 6));
				if (mix >= 78) begin
					// End marker followed by stray bytes.
					add_random($urandom_range(1, 4));
				end else if (mix >= 70) begin
					frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
				end else if (mix >= 62) begin
					cut = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > cut) void'(frame_q.pop_back());
				end
			end else begin
				add_random($urandom_range(1, 12));
			end
			ship_frame();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 14;
		recv_idle_pct = 65;

		// Short first-byte literal count, short M1 at both offset extremes.
		frame_q = {8'h12, 8'h5A, 8'h0F, 8'hFF};
		add_random(3);
		frame_q = {frame_q, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00};
		ship_frame();

		// Largest first byte, long M1, extended literal run, M2, M3 and M4 extremes.
		frame_q = {8'hFF};
		add_random(238);
		frame_q = {frame_q, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
		add_random(274);
		frame_q = {frame_q, 8'hFF, 8'hFF};
		add_random(3);
		frame_q = {frame_q, 8'h20, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		add_random(3);
		frame_q = {frame_q, 8'h1F, 8'hFF, 8'hFF};
		add_random(3);
		frame_q = {frame_q, 8'h40, 8'h00, 8'h01};
		add_random(4);
		frame_q = {frame_q, 8'h10, 8'h01, 8'h04, 8'h00, 8'h11, 8'h00, 8'h00};
		ship_frame();

		// Longest literal run that is still accepted, cut short after a few literals.
		frame_q = {8'h00};
		add_zeros(64);
		frame_q.push_back(8'd53);
		add_random(3);
		ship_frame();

		// Literal run one too long, then bytes that are dropped.
		frame_q = {8'h00};
		add_zeros(64);
		frame_q.push_back(8'd54);
		add_random(3);
		ship_frame();

		drain();

		// End marker before the last byte, a stream cut short on a literal, one cut
		// just after a first-byte literal count, and an extended end marker as the first token.
		frame_q = {8'h11, 8'h00, 8'h00, 8'hAB};
		ship_frame();
		frame_q = {8'h15};
		add_random(4);
		ship_frame();
		frame_q = {8'h20};
		ship_frame();
		frame_q = {8'h10, 8'h05, 8'h03, 8'h00};
		ship_frame();

		random_traffic(30);
		drain();

		send_idle_pct = 65;
		recv_idle_pct = 14;
		random_traffic(40);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(40);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: lzo1x_token_decoder_top.f
rtl/lzotd_pkg.sv
rtl/lzo1x_token_decoder_top.sv
rtl/lzotd_checker.sv
tb/lzotd_token_check.sv
tb/tb_top.sv
